@@ rtl/assert_macros.svh @@
// Assertion helper macros shared by the region filter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/ator_pkg.sv @@
// Package for the above-threshold region filter: widths, register indexes,
// reset values, status codes and the configuration struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ator_pkg;

   // Sample and result field widths
   localparam int SAMPLE_W   = 16;
   localparam int REGION_W   = 15;
   localparam int STATUS_W   = 2;
   localparam int MIN_LEN_W  = 8;

   // Default saturation point of the position counter
   localparam int MAX_LENGTH_DEFAULT = 16384;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISORDER    = 2'd2;

   // Register reset values (0.5 and 0.09 in Q0.16, six positions)
   localparam logic [SAMPLE_W-1:0]  PROB_THRESHOLD_RST = 16'd32768;
   localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST     = 8'd6;
   localparam logic [SAMPLE_W-1:0]  MIN_DISORDER_RST   = 16'd5898;

   localparam logic [SAMPLE_W-1:0]  FULL_SCALE = '1;

   // Region status codes
   localparam logic [STATUS_W-1:0] STATUS_KEPT         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LOW_DISORDER = 2'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  prob_threshold;
      logic [MIN_LEN_W-1:0] min_length;
      logic [SAMPLE_W-1:0]  min_disorder;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/ator_if.sv @@
// Channel interfaces for the region filter: sample input, region output and
// configuration write. Depends on ator_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ator_req_if import ator_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] probability;
   logic [SAMPLE_W-1:0] disorder;
   logic                is_last;

   modport source (output valid, probability, disorder, is_last, input ready);
   modport sink   (input valid, probability, disorder, is_last, output ready);
endinterface

interface ator_rsp_if import ator_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [REGION_W-1:0] region_start;
   logic [REGION_W-1:0] region_end;
   logic [REGION_W-1:0] region_length;
   logic [STATUS_W-1:0] region_status;

   modport source (output valid, region_start, region_end, region_length, region_status,
                   input ready);
   modport sink   (input valid, region_start, region_end, region_length, region_status,
                   output ready);
endinterface

interface ator_csr_if import ator_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/above_threshold_region_filter.sv @@
// Top level of the above-threshold region filter.
// Depends on ator_pkg, ator_if, ator_csr and ator_core.
//
// Usage:
//   req_bus  carries one sample per sequence position (probability, disorder,
//            is_last); a transfer happens when valid and ready are both high.
//   rsp_bus  carries one region item (start, end, length, status) each time a
//            run above probability_threshold closes or the sequence ends open.
//   csr_bus  writes the three configuration registers by index; it is always
//            ready and should only be used while no samples are in flight.
// Timing:
//   A sample sits in the input register until the result slot is free, then
//   the run state and the result register update together, so a region passes
//   through the input register and the result register before it shows on
//   rsp_bus. One sample is taken per cycle while the result slot is free; the
//   position counter and run state update together.
// Reset: clears the run state and restores the register defaults; no output
//   is pending afterwards.
// Stall: while a region waits on rsp_bus, the input register still takes one
//   more sample; further samples wait until the region is taken.
`timescale 1ns / 1ps
`default_nettype none

module above_threshold_region_filter import ator_pkg::*; #(
   parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ator_req_if.sink    req_bus,
   ator_rsp_if.source  rsp_bus,
   ator_csr_if.sink    csr_bus
);

   cfg_type cfg;

   ator_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   ator_core #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

@@ rtl/ator_csr.sv @@
// Configuration registers of the region filter, written over the csr channel.
// Depends on ator_pkg and ator_if.
`timescale 1ns / 1ps
`default_nettype none

module ator_csr import ator_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   ator_csr_if.sink    csr_bus,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_bus.ready = 1'b1;

   // Register decode; writes to unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_PROB_THRESHOLD: cfg_in.prob_threshold = csr_bus.data;
            CSR_MIN_LENGTH:     cfg_in.min_length     = csr_bus.data[MIN_LEN_W-1:0];
            CSR_MIN_DISORDER:   cfg_in.min_disorder   = csr_bus.data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prob_threshold <= PROB_THRESHOLD_RST;
         cfg_ff.min_length     <= MIN_LENGTH_RST;
         cfg_ff.min_disorder   <= MIN_DISORDER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/ator_core.sv @@
// Region tracking datapath: input register, run state and result register.
// Depends on ator_pkg, ator_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ator_core import ator_pkg::*; #(
   parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire cfg_type cfg,
   ator_req_if.sink    req_bus,
   ator_rsp_if.source  rsp_bus
);

   localparam int POS_W = $clog2(MAX_LENGTH + 1);
   localparam int EXT_W = (POS_W > REGION_W) ? POS_W : REGION_W;
   localparam int CMP_W = (POS_W > MIN_LEN_W) ? POS_W : MIN_LEN_W;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0] s1_prob_ff, s1_dis_ff;
   logic                s1_last_ff;

   // Run state
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                in_region_ff, in_region_in;
   logic [POS_W-1:0]    start_ff, start_in;
   logic [SAMPLE_W-1:0] run_min_ff, run_min_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [REGION_W-1:0] rsp_start_ff, rsp_end_ff, rsp_len_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // Datapath intermediates
   logic                req_xfer, out_free, s1_go;
   logic                above, close_drop, emit;
   logic [POS_W-1:0]    idx, emit_start, emit_end, emit_len;
   logic [SAMPLE_W-1:0] min_base, min_upd, emit_min;
   logic [STATUS_W-1:0] emit_status;
   logic [EXT_W-1:0]    start_ext, end_ext, len_ext;

   // Handshake: the input register drains whenever the result slot is free
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_go         = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // Region evaluation for the sample held in the input register
   always_comb begin
      above      = s1_prob_ff > cfg.prob_threshold;
      idx        = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
      close_drop = !above && in_region_ff;

      // a fresh run restarts the minimum at full scale
      min_base = in_region_ff ? run_min_ff : FULL_SCALE;
      min_upd  = (s1_dis_ff < min_base) ? s1_dis_ff : min_base;

      emit_start = (above && !in_region_ff) ? idx : start_ff;
      emit_end   = close_drop ? pos_ff : idx;
      emit_min   = close_drop ? run_min_ff : min_upd;
      emit_len   = emit_end - emit_start + POS_W'(1);
      emit       = close_drop || (s1_last_ff && above);

      // too short takes priority over low disorder
      if (CMP_W'(emit_len) < CMP_W'(cfg.min_length)) begin
         emit_status = STATUS_TOO_SHORT;
      end else if (emit_min < cfg.min_disorder) begin
         emit_status = STATUS_LOW_DISORDER;
      end else begin
         emit_status = STATUS_KEPT;
      end

      start_ext = EXT_W'(emit_start);
      end_ext   = EXT_W'(emit_end);
      len_ext   = EXT_W'(emit_len);
   end

   // Next run state; a sequence end returns everything to reset values
   always_comb begin
      pos_in       = pos_ff;
      in_region_in = in_region_ff;
      start_in     = start_ff;
      run_min_in   = run_min_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            pos_in       = '0;
            in_region_in = 1'b0;
            start_in     = '0;
            run_min_in   = FULL_SCALE;
         end else begin
            pos_in       = idx;
            in_region_in = above;
            start_in     = emit_start;
            run_min_in   = above ? min_upd : FULL_SCALE;
         end
      end
   end

   // Valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         in_region_ff <= 1'b0;
         start_ff     <= '0;
         run_min_ff   <= FULL_SCALE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         in_region_ff <= in_region_in;
         start_ff     <= start_in;
         run_min_ff   <= run_min_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_prob_ff <= req_bus.probability;
         s1_dis_ff  <= req_bus.disorder;
         s1_last_ff <= req_bus.is_last;
      end
      if (s1_go && emit) begin
         rsp_start_ff  <= start_ext[REGION_W-1:0];
         rsp_end_ff    <= end_ext[REGION_W-1:0];
         rsp_len_ff    <= len_ext[REGION_W-1:0];
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.region_start  = rsp_start_ff;
   assign rsp_bus.region_end    = rsp_end_ff;
   assign rsp_bus.region_length = rsp_len_ff;
   assign rsp_bus.region_status = rsp_status_ff;

   // Checks
   `ASSERT_IMPLY(a_pos_saturates, clock, reset, 1'b1, pos_ff <= POS_MAX)
   `ASSERT_IMPLY(a_open_run_order, clock, reset, in_region_ff,
                 (start_ff != '0) && (start_ff <= pos_ff))
   `ASSERT_IMPLY(a_idle_min_full, clock, reset, !in_region_ff, run_min_ff == FULL_SCALE)
   `ASSERT_NEXT(a_last_clears, clock, reset, s1_go && s1_last_ff,
                (pos_ff == '0) && !in_region_ff)

endmodule

`default_nettype wire
